// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication holds on every clock outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/ccsi_pkg.sv =====
// Types, constants and saturating add for the column cumulative sum block.
package ccsi_pkg;

	localparam int PIX_W     = 8;
	localparam int SUM_W     = 19;
	localparam int NCH       = 3;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 1;

	// Tallest frame the sums are sized for; the cap is the smaller bound.
	localparam int unsigned MAX_ROWS  = 2048;
	localparam int unsigned SUM_LIMIT = 522240;
	localparam int unsigned SUM_CAP_I =
		(MAX_ROWS * 255 < SUM_LIMIT) ? MAX_ROWS * 255 : SUM_LIMIT;

	typedef logic [PIX_W-1:0]     pix_t;
	typedef logic [SUM_W-1:0]     sum_t;
	typedef logic [CFG_W-1:0]     cfg_data_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef pix_t [NCH-1:0]       pix_vec_t;
	typedef sum_t [NCH-1:0]       sum_vec_t;

	localparam sum_t SUM_CAP = SUM_W'(SUM_CAP_I);

	// Register indexes on the configuration port.
	localparam cfg_idx_t REG_LINE_WIDTH = 1'd0;
	localparam cfg_idx_t REG_THREE_CHAN = 1'd1;

	localparam cfg_data_t LINE_WIDTH_RST = 12'd2048;

	// Add a pixel to a column sum, pinning at the cap.
	function automatic sum_t sat_add(input sum_t a, input pix_t b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + (SUM_W + 1)'(b);
		if (s > (SUM_W + 1)'(SUM_CAP))
			return SUM_CAP;
		return s[SUM_W-1:0];
	endfunction

	// First-row value: the pixel itself, pinned at the cap.
	function automatic sum_t sat_pix(input pix_t b);
		if (SUM_W'(b) > SUM_CAP)
			return SUM_CAP;
		return SUM_W'(b);
	endfunction

endpackage

// ===== rtl/ccsi_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
module ccsi_ram #(
	parameter int WIDTH = 57,
	parameter int DEPTH = 2048
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one word, read one word; read data is old data on collision.
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/column_cumulative_sum_image.sv =====
// Top level: per-column running sum over a raster pixel stream.
`include "assert_macros.svh"

// Column cumulative sum. Pixels enter in raster order, one word per clock
// while in_stall is low, and each yields one word with the sum of its column
// from the top row of the frame down to this row, per channel, saturating at
// the sum cap. The block sustains one pixel per clock while out_stall is low;
// a result passes the line store read, then add and output register. That
// rate is set by the line store, a MAX_COLS-deep RAM doing one read and one
// write per clock; a forward path covers a column that is read right after
// it is written (narrow rows). frame_start restarts row and column; a
// line_width of zero or above MAX_COLS means MAX_COLS. The store needs no
// clearing pass, so pixels are taken right after reset; a column not yet
// written in the current frame (width raised mid-frame) reads undefined sums.
module column_cumulative_sum_image #(
	parameter int MAX_COLS = 2048
) (
	input  logic                clk,
	input  logic                arst_n,
	// pixel input
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                frame_start,
	input  ccsi_pkg::pix_t      chan0,
	input  ccsi_pkg::pix_t      chan1,
	input  ccsi_pkg::pix_t      chan2,
	// sum output
	output logic                out_valid,
	input  logic                out_stall,
	output ccsi_pkg::sum_t      sum0,
	output ccsi_pkg::sum_t      sum1,
	output ccsi_pkg::sum_t      sum2,
	// configuration writes
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  ccsi_pkg::cfg_idx_t  cfg_index,
	input  ccsi_pkg::cfg_data_t cfg_data
);

	import ccsi_pkg::*;

	localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int CNT_W = $clog2(MAX_COLS + 1);
	localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam logic [CMP_W-1:0] MAX_COLS_C = CMP_W'(MAX_COLS);

	// Configuration registers
	cfg_data_t         line_width_q;
	logic              three_chan_q;

	// Row and column tracking
	logic [COL_W-1:0]  col_q;
	logic              first_q;
	logic [CMP_W-1:0]  width;
	logic [CMP_W-1:0]  lw_ext;
	logic [COL_W-1:0]  col_start;
	logic              first_start;
	logic [COL_W-1:0]  col_cur;
	logic              first_cur;
	logic [CMP_W-1:0]  col_inc;
	logic              wrap;
	logic              acc;
	pix_vec_t          pix_in;

	// Stage 1: line store data arrives, sums form
	logic              vld_s1;
	logic [COL_W-1:0]  col_s1;
	logic              first_s1;
	pix_vec_t          pix_s1;
	logic              adv_s1;
	sum_vec_t          rd_sums;
	sum_vec_t          base_sums;
	sum_vec_t          new_sums;

	// Last word written to the line store
	logic              fwd_vld_q;
	logic [COL_W-1:0]  fwd_col_q;
	sum_vec_t          fwd_sums_q;

	// Stage 2: output register
	logic              vld_s2;
	sum_vec_t          sums_s2;

	assign cfg_ready = 1'b1;

	// Decode configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RST;
			three_chan_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LINE_WIDTH: line_width_q <= cfg_data;
				REG_THREE_CHAN: three_chan_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Effective row width: zero or oversize means the full store
	always_comb begin
		lw_ext = CMP_W'(line_width_q);
		if (lw_ext == '0 || lw_ext > MAX_COLS_C)
			width = MAX_COLS_C;
		else
			width = lw_ext;
	end

	assign acc = in_valid && !in_stall;

	// Place the incoming pixel: restart on frame start, wrap a finished row
	always_comb begin
		col_start   = frame_start ? '0 : col_q;
		first_start = frame_start | first_q;
		if (CMP_W'(col_start) >= width) begin
			col_cur   = '0;
			first_cur = 1'b0;
		end else begin
			col_cur   = col_start;
			first_cur = first_start;
		end
		col_inc = CMP_W'(col_cur) + CMP_W'(1);
		wrap    = (col_inc >= width);
	end

	// Advance the column counter on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			first_q <= 1'b1;
		end else if (acc) begin
			col_q   <= wrap ? '0 : col_inc[COL_W-1:0];
			first_q <= wrap ? 1'b0 : first_cur;
		end
	end

	// Drop channels one and two in single-channel mode
	always_comb begin
		pix_in[0] = chan0;
		pix_in[1] = three_chan_q ? chan1 : '0;
		pix_in[2] = three_chan_q ? chan2 : '0;
	end

	// Pipeline control
	assign adv_s1   = vld_s1 && (!vld_s2 || !out_stall);
	assign in_stall = vld_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_s1 || !vld_s1)
				vld_s1 <= acc;
			if (adv_s1)
				vld_s2 <= 1'b1;
			else if (!out_stall)
				vld_s2 <= 1'b0;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (acc) begin
			col_s1   <= col_cur;
			first_s1 <= first_cur;
			pix_s1   <= pix_in;
		end
	end

	// Line store: read at accept, write back when stage 1 advances
	ccsi_ram #(
		.WIDTH ($bits(sum_vec_t)),
		.DEPTH (MAX_COLS)
	) u_line_store (
		.clk   (clk),
		.we    (adv_s1),
		.waddr (col_s1),
		.wdata (new_sums),
		.re    (acc),
		.raddr (col_cur),
		.rdata (rd_sums)
	);

	// Forward the last written column over stale store data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fwd_vld_q <= 1'b0;
		else if (adv_s1)
			fwd_vld_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			fwd_col_q  <= col_s1;
			fwd_sums_q <= new_sums;
		end
	end

	assign base_sums = (fwd_vld_q && fwd_col_q == col_s1) ? fwd_sums_q : rd_sums;

	// Add pixel to column sum, or start the column on the first row
	always_comb begin
		for (int k = 0; k < NCH; k++) begin
			if (first_s1)
				new_sums[k] = sat_pix(pix_s1[k]);
			else
				new_sums[k] = sat_add(base_sums[k], pix_s1[k]);
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (adv_s1)
			sums_s2 <= new_sums;
	end

	assign out_valid = vld_s2;
	assign sum0      = sums_s2[0];
	assign sum1      = sums_s2[1];
	assign sum2      = sums_s2[2];

	// Checks
	`ASSERT_CLK(a_stall_needs_s1, in_stall |-> vld_s1, "input stalled with stage 1 empty")
	`ASSERT_CLK(a_acc_fills_s1, acc |=> vld_s1, "accepted word did not reach stage 1")
	`ASSERT_CLK(a_frame_first_row, (acc && frame_start) |=> first_s1, "frame start not on first row")
	`ASSERT_NEVER(a_col_range, vld_s1 && (CMP_W'(col_s1) >= MAX_COLS_C), "column beyond line store")

endmodule
